>>> hw/rtl/pmbus_linear_format_codec_unit_defines.svh
// ----------------------------------------------------------------------------
// PMBus linear format codec - assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PMBUS_LINEAR_FORMAT_CODEC_UNIT_DEFINES_SVH
`define PMBUS_LINEAR_FORMAT_CODEC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PLFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("plfc assertion failed");
`define PLFC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("plfc reset assertion failed");
`else
`define PLFC_ASSERT(lbl, clk, rst_n, prop)
`define PLFC_ASSERT_RST(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/plfc_pkg.sv
// ----------------------------------------------------------------------------
// PMBus linear format codec - package
// Widths, command codes, request type and the shared rounding shift.
// ----------------------------------------------------------------------------
package plfc_pkg;

    localparam int VAL_W  = 48;
    localparam int WORD_W = 16;
    localparam int MANT_W = 11;
    localparam int EXP_W  = 5;
    localparam int CMD_W  = 2;

    // exponent + 16 over five bits is the exponent with its top bit flipped
    localparam logic [EXP_W-1:0] EXP_BIAS = 5'b10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_DEC11 = 2'd0,
        CMD_ENC11 = 2'd1,
        CMD_DEC16 = 2'd2,
        CMD_ENC16 = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic [WORD_W-1:0]        raw_word;
        logic signed [VAL_W-1:0]  in_value;
        logic signed [EXP_W-1:0]  exponent_16;
    } t_req;

    // magnitude / 2^sh, rounded half away from zero
    function automatic logic [VAL_W:0] round_shift(input logic [VAL_W-1:0] mag,
                                                   input logic [EXP_W-1:0] sh);
        logic [VAL_W:0] half;
        half = (sh == '0) ? '0 : ((VAL_W+1)'(1) << (sh - 1'b1));
        return ({1'b0, mag} + half) >> sh;
    endfunction

endpackage

>>> hw/rtl/plfc_in_if.sv
// ----------------------------------------------------------------------------
// PMBus linear format codec - request channel
// Valid/ready channel carrying one conversion request.
// ----------------------------------------------------------------------------
interface plfc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [plfc_pkg::CMD_W-1:0]             cmd;
    logic [plfc_pkg::WORD_W-1:0]            raw_word;
    logic signed [plfc_pkg::VAL_W-1:0]      in_value;
    logic signed [plfc_pkg::EXP_W-1:0]      exponent_16;

    modport source (output valid, cmd, raw_word, in_value, exponent_16, input ready);
    modport sink   (input valid, cmd, raw_word, in_value, exponent_16, output ready);
endinterface

>>> hw/rtl/plfc_out_if.sv
// ----------------------------------------------------------------------------
// PMBus linear format codec - result channel
// Valid/ready channel carrying one conversion result.
// ----------------------------------------------------------------------------
interface plfc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [plfc_pkg::WORD_W-1:0]            out_word;
    logic signed [plfc_pkg::VAL_W-1:0]      out_value;

    modport source (output valid, out_word, out_value, input ready);
    modport sink   (input valid, out_word, out_value, output ready);
endinterface

>>> hw/rtl/plfc_decode.sv
// ----------------------------------------------------------------------------
// PMBus linear format codec - decoder
// LINEAR11 and LINEAR16 words to 48-bit fixed point, 16 fractional bits.
// ----------------------------------------------------------------------------
module plfc_decode (
    input  plfc_pkg::t_req                      i_req,
    output logic signed [plfc_pkg::VAL_W-1:0]   o_value
);

    logic [plfc_pkg::EXP_W-1:0] w_sh11;
    logic [plfc_pkg::EXP_W-1:0] w_sh16;
    logic [plfc_pkg::VAL_W-1:0] w_m11;
    logic [plfc_pkg::VAL_W-1:0] w_m16;

    assign w_sh11 = i_req.raw_word[plfc_pkg::WORD_W-1 -: plfc_pkg::EXP_W] ^ plfc_pkg::EXP_BIAS;
    assign w_sh16 = i_req.exponent_16 ^ plfc_pkg::EXP_BIAS;

    assign w_m11 = {{(plfc_pkg::VAL_W-plfc_pkg::MANT_W){i_req.raw_word[plfc_pkg::MANT_W-1]}},
                    i_req.raw_word[plfc_pkg::MANT_W-1:0]};
    assign w_m16 = {{(plfc_pkg::VAL_W-plfc_pkg::WORD_W){1'b0}}, i_req.raw_word};

    always_comb begin
        case (i_req.cmd)
            plfc_pkg::CMD_DEC11: o_value = w_m11 << w_sh11;
            plfc_pkg::CMD_DEC16: o_value = w_m16 << w_sh16;
            default:             o_value = '0;
        endcase
    end

endmodule

>>> hw/rtl/plfc_encode.sv
// ----------------------------------------------------------------------------
// PMBus linear format codec - encoder
// Fixed point to LINEAR11 (exponent search) and LINEAR16 (given exponent).
// ----------------------------------------------------------------------------
module plfc_encode (
    input  plfc_pkg::t_req                  i_req,
    output logic [plfc_pkg::WORD_W-1:0]     o_word
);

    logic                           w_neg;
    logic [plfc_pkg::VAL_W-1:0]     w_mag;
    logic [plfc_pkg::EXP_W-1:0]     w_k;
    logic [plfc_pkg::VAL_W:0]       w_r11;
    logic [plfc_pkg::MANT_W-1:0]    w_lim11;
    logic [plfc_pkg::MANT_W-1:0]    w_rc11;
    logic [plfc_pkg::MANT_W-1:0]    w_mant11;
    logic [plfc_pkg::WORD_W-1:0]    w_word11;
    logic [plfc_pkg::EXP_W-1:0]     w_sh16;
    logic [plfc_pkg::VAL_W:0]       w_r16;
    logic [plfc_pkg::WORD_W-1:0]    w_word16;

    assign w_neg = i_req.in_value[plfc_pkg::VAL_W-1];
    assign w_mag = w_neg ? (~i_req.in_value + plfc_pkg::VAL_W'(1)) : i_req.in_value;

    // smallest exponent whose mantissa range holds the exact value
    always_comb begin
        w_k = '1;
        for (int i = (1 << plfc_pkg::EXP_W) - 1; i >= 0; i--) begin
            if (w_neg ? (w_mag <= (plfc_pkg::VAL_W'(1024) << i))
                      : (w_mag <= (plfc_pkg::VAL_W'(1023) << i))) begin
                w_k = plfc_pkg::EXP_W'(i);
            end
        end
    end

    assign w_r11    = plfc_pkg::round_shift(w_mag, w_k);
    assign w_lim11  = w_neg ? plfc_pkg::MANT_W'(1024) : plfc_pkg::MANT_W'(1023);
    assign w_rc11   = (w_r11 > (plfc_pkg::VAL_W+1)'(w_lim11)) ? w_lim11
                                                              : w_r11[plfc_pkg::MANT_W-1:0];
    assign w_mant11 = w_neg ? (~w_rc11 + plfc_pkg::MANT_W'(1)) : w_rc11;
    assign w_word11 = (i_req.in_value == '0) ? '0
                                             : {w_k ^ plfc_pkg::EXP_BIAS, w_mant11};

    assign w_sh16   = i_req.exponent_16 ^ plfc_pkg::EXP_BIAS;
    assign w_r16    = plfc_pkg::round_shift(i_req.in_value, w_sh16);
    assign w_word16 = (w_neg || i_req.in_value == '0) ? '0 :
                      (w_r16 > (plfc_pkg::VAL_W+1)'(16'hFFFF)) ? '1 :
                      w_r16[plfc_pkg::WORD_W-1:0];

    always_comb begin
        case (i_req.cmd)
            plfc_pkg::CMD_ENC11: o_word = w_word11;
            plfc_pkg::CMD_ENC16: o_word = w_word16;
            default:             o_word = '0;
        endcase
    end

endmodule

>>> hw/rtl/pmbus_linear_format_codec_unit.sv
// ----------------------------------------------------------------------------
// PMBus linear format codec - top level
// Request register, single-pass decode/encode logic, result register.
// ----------------------------------------------------------------------------
// Converts PMBus LINEAR11/LINEAR16 words to and from signed 48-bit fixed
// point with 16 fractional bits. A request is taken every cycle while the
// result side keeps up; each result passes through the request register,
// then the result register, with the single pass of shift, exponent
// search and rounding in between. A stall on the result channel
// holds the result register; the request register then holds its request,
// and the input stalls in the same cycle once that register is full.
// Results leave in request order, one per request.
// ----------------------------------------------------------------------------
`include "pmbus_linear_format_codec_unit_defines.svh"

module pmbus_linear_format_codec_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    plfc_in_if.sink         i_req,
    plfc_out_if.source      o_rsp
);

    logic                                   r_in_valid;
    logic                                   n_in_valid;
    plfc_pkg::t_req                         r_req;
    logic                                   r_out_valid;
    logic                                   n_out_valid;
    logic [plfc_pkg::WORD_W-1:0]            r_out_word;
    logic signed [plfc_pkg::VAL_W-1:0]      r_out_value;

    logic                                   w_out_free;
    logic                                   w_adv;
    logic                                   w_acc;
    logic signed [plfc_pkg::VAL_W-1:0]      w_value;
    logic [plfc_pkg::WORD_W-1:0]            w_word;

    plfc_decode u_decode (
        .i_req   (r_req),
        .o_value (w_value)
    );

    plfc_encode u_encode (
        .i_req  (r_req),
        .o_word (w_word)
    );

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;
    assign w_acc       = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid  = w_acc ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
        n_out_valid = w_adv ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req.cmd         <= plfc_pkg::t_cmd'(i_req.cmd);
            r_req.raw_word    <= i_req.raw_word;
            r_req.in_value    <= i_req.in_value;
            r_req.exponent_16 <= i_req.exponent_16;
        end
        if (w_adv) begin
            r_out_word  <= w_word;
            r_out_value <= w_value;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_word  = r_out_word;
    assign o_rsp.out_value = r_out_value;

    `PLFC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid))
    `PLFC_ASSERT(a_one_zero, i_clk, i_rst_n, o_rsp.valid |-> ~|o_rsp.out_word || ~|o_rsp.out_value)
    `PLFC_ASSERT(a_held_req, i_clk, i_rst_n, r_in_valid && !w_adv |=> r_in_valid && $stable(r_req))

endmodule

>>> test/tb_pmbus_linear_format_codec_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PMBus linear format codec - testbench
// Sends a short table of LINEAR11/LINEAR16 encode and decode requests at the
// format extremes, rounding ties and clamp points, then about a thousand
// random requests in bursts, while the result side stalls in changing
// patterns. Each result is checked against a fixed-point conversion model
// held here, or against a typed-in value for the obvious table rows.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        logic [plfc_pkg::WORD_W-1:0]       word;
        logic signed [plfc_pkg::VAL_W-1:0] value;
    } t_result;

    typedef struct {
        bit      fixed;
        t_result result;
    } t_tag;

    typedef struct {
        plfc_pkg::t_cmd                    cmd;
        logic [plfc_pkg::WORD_W-1:0]       raw;
        logic signed [plfc_pkg::VAL_W-1:0] val;
        int                                e16;
        bit                                fixed;
        logic [plfc_pkg::WORD_W-1:0]       word;
        logic [plfc_pkg::VAL_W-1:0]        value;
    } t_row;

    logic clk;
    logic rst_n;
    int   errors;
    int   result_count;

    t_tag    request_tags[$];
    t_result expected_results[$];

    plfc_in_if  req_if ();
    plfc_out_if rsp_if ();

    pmbus_linear_format_codec_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // fixed = 1: expected word/value typed in; otherwise computed
    t_row dir_table [25] = '{
        '{plfc_pkg::CMD_DEC11, 16'h0000, 48'sh0, 0, 1'b1, 16'h0000, 48'h0000_0000_0000},
        '{plfc_pkg::CMD_DEC11, 16'h7BFF, 48'sh0, 0, 1'b1, 16'h0000, 48'h01FF_8000_0000},
        '{plfc_pkg::CMD_DEC11, 16'h83FF, 48'sh0, 0, 1'b1, 16'h0000, 48'h0000_0000_03FF},
        '{plfc_pkg::CMD_DEC11, 16'h8400, 48'sh0, 0, 1'b1, 16'h0000, 48'hFFFF_FFFF_FC00},
        '{plfc_pkg::CMD_DEC11, 16'h7C00, 48'sh0, 0, 1'b1, 16'h0000, 48'hFE00_0000_0000},
        '{plfc_pkg::CMD_DEC11, 16'hFFFF, 48'sh0, 0, 1'b1, 16'h0000, 48'hFFFF_FFFF_8000},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh0, 0, 1'b1, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh7FFF_FFFF_FFFF, 0, 1'b1, 16'h7BFF, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh8000_0000_0000, 0, 1'b1, 16'h7C00, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh0000_0001_0000, 0, 1'b1, 16'hBA00, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh1, 0, 1'b1, 16'h8001, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, -48'sh1, 0, 1'b1, 16'h87FF, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sd1025, 0, 1'b0, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, -48'sd1025, 0, 1'b0, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh01FF_8000_0000, 0, 1'b0, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC11, 16'h0000, 48'sh01FF_8000_0001, 0, 1'b0, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_DEC16, 16'hFFFF, 48'sh0, 15, 1'b1, 16'h0000, 48'h7FFF_8000_0000},
        '{plfc_pkg::CMD_DEC16, 16'h0001, 48'sh0, -16, 1'b1, 16'h0000, 48'h0000_0000_0001},
        '{plfc_pkg::CMD_DEC16, 16'h8000, 48'sh0, -1, 1'b1, 16'h0000, 48'h0000_4000_0000},
        '{plfc_pkg::CMD_ENC16, 16'h0000, -48'sh1, 0, 1'b1, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC16, 16'h0000, 48'sh0, 5, 1'b1, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC16, 16'h0000, 48'sh7FFF_FFFF_FFFF, -16, 1'b1, 16'hFFFF, 48'h0},
        '{plfc_pkg::CMD_ENC16, 16'h0000, 48'sd3, -15, 1'b0, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC16, 16'h0000, 48'sd131071, -15, 1'b0, 16'h0000, 48'h0},
        '{plfc_pkg::CMD_ENC16, 16'h0000, 48'sh0000_0001_0000, -9, 1'b1, 16'h0200, 48'h0}
    };

    // magnitude / 2^sh, ties away from zero
    function automatic longint round_away(input longint mag, input int sh);
        if (sh == 0)
            return mag;
        return (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic t_result convert(input plfc_pkg::t_req r);
        t_result res;
        longint  val;
        longint  quo;
        longint  mant;
        int      shift;
        res  = '0;
        val  = r.in_value;
        case (r.cmd)
            plfc_pkg::CMD_DEC11: begin
                shift     = $signed(r.raw_word[15:11]) + 16;
                mant      = $signed(r.raw_word[10:0]);
                res.value = 48'(mant <<< shift);
            end
            plfc_pkg::CMD_ENC11: begin
                if (val != 0) begin
                    shift = 0;
                    while (shift < 31 && (val > (64'sd1023 <<< shift) ||
                                          val < -(64'sd1024 <<< shift)))
                        shift++;
                    quo = round_away((val < 0) ? -val : val, shift);
                    if (val < 0)
                        mant = -((quo > 1024) ? 64'sd1024 : quo);
                    else
                        mant = (quo > 1023) ? 64'sd1023 : quo;
                    res.word = {5'(shift - 16), 11'(mant)};
                end
            end
            plfc_pkg::CMD_DEC16: begin
                shift     = r.exponent_16 + 16;
                res.value = 48'(longint'(r.raw_word) << shift);
            end
            default: begin
                if (val > 0) begin
                    quo      = round_away(val, r.exponent_16 + 16);
                    res.word = (quo > 65535) ? 16'hFFFF : 16'(quo);
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic signed [plfc_pkg::VAL_W-1:0] random_value();
        longint v;
        int     k;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: begin
                k = $urandom_range(1, 47);
                v = longint'({$urandom, $urandom}) >>> (64 - k);
            end
            2: begin
                k = $urandom_range(0, 31);
                v = $urandom_range(0, 1) ? (64'sd1023 <<< k) : -(64'sd1024 <<< k);
                v += int'($urandom_range(0, 4)) - 2;
            end
            3: begin
                k = $urandom_range(1, 31);
                v = (longint'(int'($urandom_range(0, 2047)) - 1024) <<< k) +
                    (64'sd1 <<< (k - 1));
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 0;
                    1: v = 1;
                    2: v = -1;
                    3: v = 64'sh0000_7FFF_FFFF_FFFF;
                    default: v = -64'sh0000_8000_0000_0000;
                endcase
            end
            default: begin
                k = $urandom_range(0, 31);
                v = (longint'($urandom_range(0, 65536)) <<< k) +
                    (longint'($urandom) & ((64'sd1 <<< k) - 1));
            end
        endcase
        return v[plfc_pkg::VAL_W-1:0];
    endfunction

    function automatic plfc_pkg::t_req random_request();
        plfc_pkg::t_req r;
        r.cmd         = plfc_pkg::t_cmd'($urandom_range(0, 3));
        r.raw_word    = 16'($urandom);
        r.in_value    = random_value();
        r.exponent_16 = 5'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic send_request(input plfc_pkg::t_req r, input bit fixed,
                                input t_result lit);
        t_tag tag;
        tag.fixed  = fixed;
        tag.result = lit;
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.cmd         <= r.cmd;
        req_if.raw_word    <= r.raw_word;
        req_if.in_value    <= r.in_value;
        req_if.exponent_16 <= r.exponent_16;
        request_tags.push_back(tag);
        do @(posedge clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // result-side stalls: ready held high, random, periodic or mostly low; mode redrawn when its countdown runs out
    initial begin
        int mode;
        int left;
        int phase;
        mode  = 0;
        left  = 0;
        phase = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(30, 150);
            end else begin
                left--;
            end
            phase++;
            case (mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= 1'($urandom_range(0, 1));
                2: rsp_if.ready <= (phase % 4 == 0);
                default: rsp_if.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    always @(posedge clk) begin
        plfc_pkg::t_req seen;
        t_tag           tag;
        t_result        want;
        if (rst_n === 1'b1) begin
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                seen.cmd         = plfc_pkg::t_cmd'(req_if.cmd);
                seen.raw_word    = req_if.raw_word;
                seen.in_value    = req_if.in_value;
                seen.exponent_16 = req_if.exponent_16;
                tag = request_tags.pop_front();
                expected_results.push_back(tag.fixed ? tag.result : convert(seen));
            end
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              result_count));
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_if.out_word !== want.word)
                        report_mismatch($sformatf("result %0d out_word %h, expected %h",
                                                  result_count, rsp_if.out_word, want.word));
                    if (rsp_if.out_value !== want.value)
                        report_mismatch($sformatf("result %0d out_value %h, expected %h",
                                                  result_count, rsp_if.out_value,
                                                  want.value));
                end
                result_count++;
            end
        end
    end

    initial begin
        plfc_pkg::t_req req;
        t_result        lit;
        t_result        none;
        int             sent;
        int             burst;
        errors             = 0;
        result_count       = 0;
        none               = '0;
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.cmd         = plfc_pkg::CMD_DEC11;
        req_if.raw_word    = '0;
        req_if.in_value    = '0;
        req_if.exponent_16 = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            req.cmd         = dir_table[i].cmd;
            req.raw_word    = dir_table[i].raw;
            req.in_value    = dir_table[i].val;
            req.exponent_16 = 5'(dir_table[i].e16);
            lit.word        = dir_table[i].word;
            lit.value       = dir_table[i].value;
            send_request(req, dir_table[i].fixed, lit);
            idle($urandom_range(0, 2));
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 16);
            repeat (burst) begin
                send_request(random_request(), 1'b0, none);
                sent++;
            end
            idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        idle(1);

        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
